// ----- rtl/ftr_pkg.sv -----
// Shared types and constants of the frame time remapper.
`timescale 1ns / 1ps
`default_nettype none
package ftr_pkg;

    // Output word width
    localparam int OUT_BITS = 29;

    // Mode register codes
    localparam logic [1:0] MODE_NORMAL   = 2'd0;
    localparam logic [1:0] MODE_REVERSE  = 2'd1;
    localparam logic [1:0] MODE_FIXED    = 2'd2;
    localparam logic [1:0] MODE_PINGPONG = 2'd3;

    // Flag bit positions
    localparam int FLAG_CUSTOM    = 0;
    localparam int FLAG_INV_LAYER = 1;
    localparam int FLAG_INV_PASS  = 2;
    localparam int FLAG_LOOP      = 3;

    // Register indexes on the APB port
    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_FLAGS  = 3'd1;
    localparam logic [2:0] REG_RSTART = 3'd2;
    localparam logic [2:0] REG_REND   = 3'd3;
    localparam logic [2:0] REG_OFFSET = 3'd4;
    localparam logic [2:0] REG_SCALE  = 3'd5;
    localparam logic [2:0] REG_LAYER  = 3'd6;
    localparam logic [2:0] REG_PASS   = 3'd7;

    // How the back end forms the result from the remainder
    typedef enum logic [1:0] {
        SEL_DIRECT,
        SEL_S_PLUS_R,
        SEL_E_MINUS_R,
        SEL_PINGPONG
    } t_sel;

endpackage
`default_nettype wire

// ----- rtl/ftr_front.sv -----
// Front end: range, offset, filters, scaling and the results that need no division.
`timescale 1ns / 1ps
`default_nettype none
module ftr_front #(
    parameter int FB = 21
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic signed [FB-1:0] i_frame,
    input  wire logic [15:0]          i_layer_id,
    input  wire logic [7:0]           i_layer_pass,
    input  wire logic signed [FB-1:0] i_scene_start,
    input  wire logic signed [FB-1:0] i_scene_end,
    input  wire logic [1:0]           i_mode,
    input  wire logic [3:0]           i_flags,
    input  wire logic signed [FB-1:0] i_range_start,
    input  wire logic signed [FB-1:0] i_range_end,
    input  wire logic signed [FB-1:0] i_frame_offset,
    input  wire logic [7:0]           i_frame_scale,
    input  wire logic [15:0]          i_layer_filter,
    input  wire logic [7:0]           i_pass_filter,
    input  wire logic                 i_full,
    output logic                      o_valid,
    output ftr_pkg::t_sel             o_sel,
    output logic signed [FB+9:0]      o_direct,
    output logic signed [FB-1:0]      o_s,
    output logic signed [FB-1:0]      o_e,
    output logic signed [FB+8:0]      o_t,
    output logic [FB-1:0]             o_div
);
    import ftr_pkg::*;

    localparam int OW = FB + 2;
    localparam int W  = FB + 10;
    localparam int TW = FB + 9;

    logic en1, en2;

    // Stage 1 signals
    logic signed [FB-1:0] s_sel, e_sel, s_c, e_c;
    logic signed [OW-1:0] tt;
    logic signed [FB:0]   off_n;
    logic                 lmiss, pmiss, byp_n;
    logic signed [TW-1:0] f_n;

    logic                 r1_valid;
    logic signed [FB-1:0] r1_cfra, r1_s, r1_e;
    logic signed [FB:0]   r1_off;
    logic signed [TW-1:0] r1_f;
    logic                 r1_byp, r1_loop;
    logic [1:0]           r1_mode;

    // Stage 2 signals
    logic signed [W-1:0]  tw, sw, ew, ow, fw, dw, ts, t2, nclamp, rclamp, n_direct;
    logic [FB-1:0]        d_n, n_div;
    t_sel                 n_sel;

    logic                 r2_valid;
    t_sel                 r2_sel;
    logic signed [W-1:0]  r2_direct;
    logic signed [FB-1:0] r2_s, r2_e;
    logic signed [TW-1:0] r2_t;
    logic [FB-1:0]        r2_div;

    assign en2     = !r2_valid || !i_full;
    assign en1     = !r1_valid || en2;
    assign o_ready = en1;

    // Working range, clamped at zero
    assign s_sel = i_flags[FLAG_CUSTOM] ? i_range_start : i_scene_start;
    assign e_sel = i_flags[FLAG_CUSTOM] ? i_range_end : i_scene_end;
    assign s_c   = s_sel[FB-1] ? '0 : s_sel;
    assign e_c   = e_sel[FB-1] ? '0 : e_sel;

    // Replace a negative offset by its reflected value
    assign tt    = OW'(e_c) - OW'(s_c) + OW'(i_frame_offset) + OW'(1);
    assign off_n = !i_frame_offset[FB-1] ? (FB+1)'(i_frame_offset) :
                   (tt[OW-1] ? (FB+1)'(-tt) : (FB+1)'(tt));

    // Filters and empty range
    assign lmiss = (i_layer_filter != '0) &&
                   ((i_layer_id == i_layer_filter) == i_flags[FLAG_INV_LAYER]);
    assign pmiss = (i_pass_filter != '0) &&
                   ((i_layer_pass == i_pass_filter) == i_flags[FLAG_INV_PASS]);
    assign byp_n = (e_c <= s_c) || lmiss || pmiss;

    // Scale the frame
    assign f_n = i_frame * $signed({1'b0, i_frame_scale});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en1) begin
            r1_valid <= i_valid;
        end
        if (en1) begin
            r1_cfra <= i_frame;
            r1_s    <= s_c;
            r1_e    <= e_c;
            r1_off  <= off_n;
            r1_f    <= f_n;
            r1_byp  <= byp_n;
            r1_loop <= i_flags[FLAG_LOOP];
            r1_mode <= i_mode;
        end
    end

    // Clamped modes and the operands of the division
    assign tw = W'(r1_f) + W'(r1_off) - W'(1);
    assign sw = W'(r1_s);
    assign ew = W'(r1_e);
    assign ow = W'(r1_off);
    assign fw = W'(r1_f);
    assign dw = ew - sw;
    assign ts = tw + sw;
    assign t2 = ew - tw - W'(1);
    assign nclamp = (ts < ew) ? ts : ew;
    assign rclamp = (t2 > sw) ? t2 + W'(1) : sw;
    assign d_n    = FB'(r1_e - r1_s);
    assign n_div  = (r1_mode == MODE_PINGPONG) ? d_n : d_n + FB'(1);

    // Pick the direct result or the way the remainder is used
    always_comb begin
        n_sel    = SEL_DIRECT;
        n_direct = sw;
        if (r1_byp) begin
            n_direct = W'(r1_cfra);
        end else begin
            unique case (r1_mode)
                MODE_FIXED: n_direct = ow;
                MODE_NORMAL: begin
                    if (r1_loop) n_sel = SEL_S_PLUS_R;
                    else n_direct = nclamp;
                end
                MODE_REVERSE: begin
                    if (r1_loop) n_sel = SEL_E_MINUS_R;
                    else n_direct = rclamp;
                end
                MODE_PINGPONG: begin
                    if (!r1_loop && (fw > dw + dw)) n_direct = sw + ow;
                    else n_sel = SEL_PINGPONG;
                end
                default: n_direct = sw;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en2) begin
            r2_valid <= r1_valid;
        end
        if (en2) begin
            r2_sel    <= n_sel;
            r2_direct <= n_direct;
            r2_s      <= r1_s;
            r2_e      <= r1_e;
            r2_t      <= TW'(tw);
            r2_div    <= n_div;
        end
    end

    assign o_valid  = r2_valid;
    assign o_sel    = r2_sel;
    assign o_direct = r2_direct;
    assign o_s      = r2_s;
    assign o_e      = r2_e;
    assign o_t      = r2_t;
    assign o_div    = r2_div;

endmodule
`default_nettype wire

// ----- rtl/ftr_queue.sv -----
// Short queue between the front end and the divider back end.
`timescale 1ns / 1ps
`default_nettype none
module ftr_queue #(
    parameter int DW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [DW-1:0] i_data,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_empty,
    output logic [DW-1:0]      o_data
);
    localparam int DEPTH = 4;

    logic [DW-1:0] r_mem [DEPTH];
    logic [1:0]    r_wptr, r_rptr;
    logic [2:0]    r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == 3'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    // Store the beat
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wptr <= r_wptr + 2'd1;
            if (do_pop)  r_rptr <= r_rptr + 2'd1;
            r_count <= r_count + 3'(do_push) - 3'(do_pop);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'(DEPTH)) else $error("queue overfilled");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("pop from empty queue");
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 3'd1))
        else $error("fill level did not grow");

endmodule
`default_nettype wire

// ----- rtl/ftr_back.sv -----
// Back end: pipelined restoring divider and final result with saturation.
`timescale 1ns / 1ps
`default_nettype none
module ftr_back #(
    parameter int FB = 21
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_empty,
    output logic                      o_pop,
    input  wire ftr_pkg::t_sel        i_sel,
    input  wire logic signed [FB+9:0] i_direct,
    input  wire logic signed [FB-1:0] i_s,
    input  wire logic signed [FB-1:0] i_e,
    input  wire logic signed [FB+8:0] i_t,
    input  wire logic [FB-1:0]        i_div,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic signed [ftr_pkg::OUT_BITS-1:0] o_mapped_frame
);
    import ftr_pkg::*;

    localparam int W  = FB + 10;
    localparam int TW = FB + 9;
    localparam int MW = TW - 1;
    localparam int N  = MW;
    localparam int SW = ((W > OUT_BITS) ? W : OUT_BITS) + 1;
    localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

    logic                 be;
    logic                 r_valid [N+1];
    t_sel                 r_sel   [N+1];
    logic signed [W-1:0]  r_dir   [N+1];
    logic signed [FB-1:0] r_s     [N+1];
    logic signed [FB-1:0] r_e     [N+1];
    logic                 r_neg   [N+1];
    logic [FB-1:0]        r_div   [N+1];
    logic [FB-1:0]        r_rem   [N+1];
    logic [MW-1:0]        r_mag   [N+1];
    logic                 r_q     [N+1];

    logic                 r_out_valid;
    logic signed [OUT_BITS-1:0] r_out;

    logic signed [W-1:0]  rem_s, rr, sw, ew, res;
    logic signed [SW-1:0] v;

    assign be    = !r_out_valid || i_ready;
    assign o_pop = be && !i_empty;

    // Load the divider operands from the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (be) begin
            r_valid[0] <= !i_empty;
        end
        if (be) begin
            r_sel[0] <= i_sel;
            r_dir[0] <= i_direct;
            r_s[0]   <= i_s;
            r_e[0]   <= i_e;
            r_neg[0] <= i_t[TW-1];
            r_div[0] <= i_div;
            r_rem[0] <= '0;
            r_mag[0] <= i_t[TW-1] ? MW'(-i_t) : MW'(i_t);
            r_q[0]   <= 1'b0;
        end
    end

    // One quotient bit per stage
    for (genvar k = 0; k < N; k++) begin : g_step
        logic [FB:0] cand;
        logic        ge;

        assign cand = {r_rem[k], r_mag[k][MW-1]};
        assign ge   = cand >= {1'b0, r_div[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else if (be) begin
                r_valid[k+1] <= r_valid[k];
            end
            if (be) begin
                r_sel[k+1] <= r_sel[k];
                r_dir[k+1] <= r_dir[k];
                r_s[k+1]   <= r_s[k];
                r_e[k+1]   <= r_e[k];
                r_neg[k+1] <= r_neg[k];
                r_div[k+1] <= r_div[k];
                r_rem[k+1] <= ge ? FB'(cand - {1'b0, r_div[k]}) : FB'(cand);
                r_mag[k+1] <= r_mag[k] << 1;
                r_q[k+1]   <= ge;
            end
        end
    end

    // Signed remainder takes the dividend's sign; quotient parity from the last bit
    assign rem_s = W'($signed({1'b0, r_rem[N]}));
    assign rr    = r_neg[N] ? -rem_s : rem_s;
    assign sw    = W'(r_s[N]);
    assign ew    = W'(r_e[N]);

    always_comb begin
        case (r_sel[N])
            SEL_DIRECT:    res = r_dir[N];
            SEL_S_PLUS_R:  res = sw + rr;
            SEL_E_MINUS_R: res = ew - rr;
            SEL_PINGPONG:  res = r_q[N] ? ew - rr : sw + rr;
            default:       res = r_dir[N];
        endcase
    end

    assign v = SW'(res);

    // Saturate into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (be) begin
            r_out_valid <= r_valid[N];
        end
        if (be) begin
            if (v > SAT_HI)      r_out <= OUT_BITS'(SAT_HI);
            else if (v < SAT_LO) r_out <= OUT_BITS'(SAT_LO);
            else                 r_out <= OUT_BITS'(v);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_mapped_frame = r_out;

endmodule
`default_nettype wire

// ----- rtl/frame_time_remapper.sv -----
// Top level of the frame time remapper: registers, front end, queue and back end.
// Throughput: one item per cycle while the output is not held back, set by the fully
// pipelined divider (FRAME_BITS + 8 stages, one quotient bit each).
// A four-entry queue parts the front end from the divider so each side stalls alone.
// Reset is synchronous, active low: registers take their defaults, pipelines empty.
`timescale 1ns / 1ps
`default_nettype none
module frame_time_remapper #(
    parameter int FRAME_BITS = 21
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic signed [FRAME_BITS-1:0] i_frame,
    input  wire logic [15:0]                  i_layer_id,
    input  wire logic [7:0]                   i_layer_pass,
    input  wire logic signed [FRAME_BITS-1:0] i_scene_start,
    input  wire logic signed [FRAME_BITS-1:0] i_scene_end,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic signed [ftr_pkg::OUT_BITS-1:0] o_mapped_frame,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [4:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import ftr_pkg::*;

    localparam int FB = FRAME_BITS;
    localparam int W  = FB + 10;
    localparam int TW = FB + 9;
    localparam int QW = 2 + W + FB + FB + TW + FB;

    logic [1:0]           r_mode;
    logic [3:0]           r_flags;
    logic signed [FB-1:0] r_range_start, r_range_end, r_frame_offset;
    logic [7:0]           r_frame_scale;
    logic [15:0]          r_layer_filter;
    logic [7:0]           r_pass_filter;
    logic                 wr_en;
    logic [2:0]           reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_NORMAL;
            r_flags        <= '0;
            r_range_start  <= FB'(1);
            r_range_end    <= FB'(250);
            r_frame_offset <= FB'(1);
            r_frame_scale  <= 8'd1;
            r_layer_filter <= '0;
            r_pass_filter  <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MODE:   r_mode         <= pwdata[1:0];
                REG_FLAGS:  r_flags        <= pwdata[3:0];
                REG_RSTART: r_range_start  <= pwdata[FB-1:0];
                REG_REND:   r_range_end    <= pwdata[FB-1:0];
                REG_OFFSET: r_frame_offset <= pwdata[FB-1:0];
                REG_SCALE:  r_frame_scale  <= pwdata[7:0];
                REG_LAYER:  r_layer_filter <= pwdata[15:0];
                REG_PASS:   r_pass_filter  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (reg_idx)
            REG_MODE:   prdata = 32'(r_mode);
            REG_FLAGS:  prdata = 32'(r_flags);
            REG_RSTART: prdata = 32'(unsigned'(r_range_start));
            REG_REND:   prdata = 32'(unsigned'(r_range_end));
            REG_OFFSET: prdata = 32'(unsigned'(r_frame_offset));
            REG_SCALE:  prdata = 32'(r_frame_scale);
            REG_LAYER:  prdata = 32'(r_layer_filter);
            REG_PASS:   prdata = 32'(r_pass_filter);
            default:    prdata = '0;
        endcase
    end

    logic                 f_valid, q_full, q_empty, q_pop;
    t_sel                 f_sel, b_sel;
    logic signed [W-1:0]  f_direct, b_direct;
    logic signed [FB-1:0] f_s, f_e, b_s, b_e;
    logic signed [TW-1:0] f_t, b_t;
    logic [FB-1:0]        f_div, b_div;
    logic [QW-1:0]        q_in, q_out;

    ftr_front #(.FB(FB)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_ready        (o_in_ready),
        .i_frame        (i_frame),
        .i_layer_id     (i_layer_id),
        .i_layer_pass   (i_layer_pass),
        .i_scene_start  (i_scene_start),
        .i_scene_end    (i_scene_end),
        .i_mode         (r_mode),
        .i_flags        (r_flags),
        .i_range_start  (r_range_start),
        .i_range_end    (r_range_end),
        .i_frame_offset (r_frame_offset),
        .i_frame_scale  (r_frame_scale),
        .i_layer_filter (r_layer_filter),
        .i_pass_filter  (r_pass_filter),
        .i_full         (q_full),
        .o_valid        (f_valid),
        .o_sel          (f_sel),
        .o_direct       (f_direct),
        .o_s            (f_s),
        .o_e            (f_e),
        .o_t            (f_t),
        .o_div          (f_div)
    );

    // Pack and unpack queue beats
    assign q_in = {f_sel, f_direct, f_s, f_e, f_t, f_div};
    assign {b_sel, b_direct, b_s, b_e, b_t, b_div} = q_out;

    ftr_queue #(.DW(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    ftr_back #(.FB(FB)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (q_empty),
        .o_pop          (q_pop),
        .i_sel          (b_sel),
        .i_direct       (b_direct),
        .i_s            (b_s),
        .i_e            (b_e),
        .i_t            (b_t),
        .i_div          (b_div),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_mapped_frame (o_mapped_frame)
    );

endmodule
`default_nettype wire

// ----- test/frame_time_remapper_chk.sv -----
// Checker of the frame time remapper: predicts each mapped frame and compares it.
`timescale 1ns / 1ps
module frame_time_remapper_chk #(
    parameter int FRAME_BITS = 21
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic signed [FRAME_BITS-1:0]  i_frame,
    input  logic [15:0]                   i_layer_id,
    input  logic [7:0]                    i_layer_pass,
    input  logic signed [FRAME_BITS-1:0]  i_scene_start,
    input  logic signed [FRAME_BITS-1:0]  i_scene_end,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic signed [ftr_pkg::OUT_BITS-1:0] i_mapped_frame,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [4:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output int                            o_fail_count,
    output int                            o_pending
);
    import ftr_pkg::*;

    // Shadow copy of the registers
    logic [1:0]                   cfg_mode;
    logic [3:0]                   cfg_flags;
    logic signed [FRAME_BITS-1:0] cfg_rstart, cfg_rend, cfg_offset;
    logic [7:0]                   cfg_scale;
    logic [15:0]                  cfg_layer;
    logic [7:0]                   cfg_pass;

    logic signed [OUT_BITS-1:0] expected_frames[$];

    assign o_pending = expected_frames.size();

    // Saturate to the output word
    function automatic logic signed [OUT_BITS-1:0] sat(longint v);
        longint hi, lo;
        hi = (longint'(1) <<< (OUT_BITS - 1)) - 1;
        lo = -(longint'(1) <<< (OUT_BITS - 1));
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[OUT_BITS-1:0];
    endfunction

    function automatic logic signed [OUT_BITS-1:0] map_frame(
        longint cfra, longint lid, longint lpass, longint scn_s, longint scn_e);
        longint s, e, off, f, d, t, q, r, nfra;
        s = cfg_flags[FLAG_CUSTOM] ? longint'(cfg_rstart) : scn_s;
        e = cfg_flags[FLAG_CUSTOM] ? longint'(cfg_rend) : scn_e;
        if (s < 0) s = 0;
        if (e < 0) e = 0;
        off = cfg_offset;
        if (off < 0) begin
            t = e - s + off + 1;
            off = t < 0 ? -t : t;
        end
        nfra = cfra;
        if (e <= s) return sat(cfra);
        if (cfg_layer != 0 && ((lid == cfg_layer) == cfg_flags[FLAG_INV_LAYER]))
            return sat(cfra);
        if (cfg_pass != 0 && ((lpass == cfg_pass) == cfg_flags[FLAG_INV_PASS]))
            return sat(cfra);
        f = cfra * longint'(cfg_scale);
        d = e - s;
        case (cfg_mode)
            MODE_FIXED: nfra = off;
            MODE_NORMAL: begin
                if (!cfg_flags[FLAG_LOOP]) begin
                    t = f + s + off - 1;
                    nfra = t < e ? t : e;
                end else begin
                    nfra = (off + f - 1) % (d + 1) + s;
                end
            end
            MODE_REVERSE: begin
                if (!cfg_flags[FLAG_LOOP]) begin
                    t = e - f - off;
                    nfra = t > s ? t + 1 : s;
                end else begin
                    nfra = (e + 1 - (f + off - 1) % (d + 1)) - 1;
                end
            end
            default: begin
                t = f + off - 1;
                q = t / d;
                r = t % d;
                nfra = (q % 2 != 0) ? e - r : s + r;
                if (!cfg_flags[FLAG_LOOP] && f > d * 2) nfra = s + off;
            end
        endcase
        return sat(nfra);
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_mode   <= MODE_NORMAL;
            cfg_flags  <= '0;
            cfg_rstart <= FRAME_BITS'(1);
            cfg_rend   <= FRAME_BITS'(250);
            cfg_offset <= FRAME_BITS'(1);
            cfg_scale  <= 8'd1;
            cfg_layer  <= '0;
            cfg_pass   <= '0;
            expected_frames.delete();
        end else begin
            // Track register writes
            if (psel && penable && pwrite) begin
                case (paddr[4:2])
                    REG_MODE:   cfg_mode   <= pwdata[1:0];
                    REG_FLAGS:  cfg_flags  <= pwdata[3:0];
                    REG_RSTART: cfg_rstart <= pwdata[FRAME_BITS-1:0];
                    REG_REND:   cfg_rend   <= pwdata[FRAME_BITS-1:0];
                    REG_OFFSET: cfg_offset <= pwdata[FRAME_BITS-1:0];
                    REG_SCALE:  cfg_scale  <= pwdata[7:0];
                    REG_LAYER:  cfg_layer  <= pwdata[15:0];
                    REG_PASS:   cfg_pass   <= pwdata[7:0];
                    default: ;
                endcase
            end
            // Predict each input beat
            if (i_in_valid && i_in_ready)
                expected_frames.push_back(map_frame(i_frame, i_layer_id, i_layer_pass,
                                                    i_scene_start, i_scene_end));
            // Compare each result beat
            if (i_out_valid && i_out_ready) begin
                if (expected_frames.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0d", i_mapped_frame));
                end else begin
                    if (i_mapped_frame !== expected_frames[0])
                        report_mismatch($sformatf("mapped_frame %0d, want %0d",
                                                  i_mapped_frame, expected_frames[0]));
                    void'(expected_frames.pop_front());
                end
            end
        end
    end
endmodule

// ----- test/frame_time_remapper_tb.sv -----
// Testbench top of the frame time remapper: stimulus, register writes and verdict.
`timescale 1ns / 1ps
module frame_time_remapper_tb;
    import ftr_pkg::*;

    localparam int FB = 21;
    localparam int LATENCY = FB + 14;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk, i_rst_n;
    logic i_in_valid, o_in_ready, o_out_valid, i_out_ready;
    logic signed [FB-1:0] i_frame, i_scene_start, i_scene_end;
    logic [15:0] i_layer_id;
    logic [7:0]  i_layer_pass;
    logic signed [OUT_BITS-1:0] o_mapped_frame;
    logic psel, penable, pwrite, pready;
    logic [4:0] paddr;
    logic [31:0] pwdata, prdata;
    int fail_count, pending, cycles;
    int hold_off, no_idle, sent;

    frame_time_remapper #(.FRAME_BITS(FB)) dut (.*);

    frame_time_remapper_chk #(.FRAME_BITS(FB)) chk (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready), .i_frame,
        .i_layer_id, .i_layer_pass, .i_scene_start, .i_scene_end,
        .i_out_valid(o_out_valid), .i_out_ready, .i_mapped_frame(o_mapped_frame),
        .psel, .penable, .pwrite, .paddr, .pwdata,
        .o_fail_count(fail_count), .o_pending(pending));

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Receiver: random stalls, a quiet stretch, and long hold-offs
    initial begin
        i_out_ready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                hold_off--;
                i_out_ready <= 0;
            end else begin
                i_out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 26);
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // Drop valid, wait until all results are back, then let the pipeline drain
    task automatic settle();
        i_in_valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
    endtask

    // Offer one beat; valid stays high into the next beat unless a gap is taken
    task automatic send_beat(input logic signed [FB-1:0] fr, input logic [15:0] lid,
                             input logic [7:0] lp, input logic signed [FB-1:0] ss,
                             input logic signed [FB-1:0] se);
        int gap;
        gap = 0;
        if (!no_idle)
            while ($urandom_range(99) < 26) gap++;
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1;
        i_frame <= fr; i_layer_id <= lid; i_layer_pass <= lp;
        i_scene_start <= ss; i_scene_end <= se;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    function automatic logic signed [FB-1:0] any_frame();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(300);
            2: return -$signed({1'b0, $urandom_range(20)});
            default: return $urandom_range(2000);
        endcase
    endfunction

    task automatic random_config();
        write_reg(REG_MODE, $urandom_range(3));
        write_reg(REG_FLAGS, $urandom_range(15));
        write_reg(REG_RSTART, $urandom_range(3) == 0 ? $urandom : $urandom_range(100) - 10);
        write_reg(REG_REND, $urandom_range(3) == 0 ? $urandom : $urandom_range(400) - 10);
        write_reg(REG_OFFSET, $urandom_range(3) == 0 ? $urandom : $urandom_range(60) - 30);
        write_reg(REG_SCALE, $urandom_range(3) == 0 ? $urandom : $urandom_range(4));
        write_reg(REG_LAYER, $urandom_range(2) == 0 ? $urandom_range(3) : $urandom);
        write_reg(REG_PASS, $urandom_range(2) == 0 ? $urandom_range(3) : $urandom);
    endtask

    task automatic random_beat();
        logic signed [FB-1:0] ss;
        ss = $urandom_range(3) == 0 ? $urandom : $urandom_range(50) - 5;
        send_beat(any_frame(), $urandom_range(1) ? $urandom_range(3) : $urandom,
                  $urandom_range(1) ? $urandom_range(3) : $urandom, ss,
                  $urandom_range(3) == 0 ? $urandom : ss + $urandom_range(300) - 5);
    endtask

    initial begin
        i_rst_n = 0; i_in_valid = 0; i_frame = 0; i_layer_id = 0; i_layer_pass = 0;
        i_scene_start = 0; i_scene_end = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        hold_off = 0; no_idle = 0; sent = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Directed: reset settings, extremes, empty range
        send_beat(0, 0, 0, 0, 100);
        send_beat(21'sh0FFFFF, 16'hFFFF, 8'hFF, 21'sh100000, 21'sh0FFFFF);
        send_beat(21'sh100000, 0, 0, 0, 21'sh0FFFFF);
        send_beat(50, 1, 1, 100, 100);
        send_beat(50, 1, 1, 200, 100);
        // Every mode, clamp and loop, with large scale and extreme registers
        for (int m = 0; m < 4; m++) begin
            for (int lp = 0; lp < 2; lp++) begin
                settle();
                write_reg(REG_MODE, m);
                write_reg(REG_FLAGS, lp ? 32'h9 : 32'h1);
                write_reg(REG_RSTART, lp ? 32'hFFF00000 : 10);
                write_reg(REG_REND, lp ? 32'h000FFFFF : 30);
                write_reg(REG_OFFSET, lp ? 32'hFFFFFFFB : 32'h000FFFFF);
                write_reg(REG_SCALE, lp ? 255 : 0);
                send_beat(7, 0, 0, 0, 0);
                send_beat(lp ? 21'sh0FFFFF : -3, 0, 0, 0, 0);
            end
        end
        // Filters, plain and inverted
        settle();
        write_reg(REG_MODE, MODE_NORMAL);
        write_reg(REG_FLAGS, 0);
        write_reg(REG_SCALE, 1);
        write_reg(REG_LAYER, 16'hFFFF);
        write_reg(REG_PASS, 8'hFF);
        send_beat(20, 16'hFFFF, 8'hFF, 0, 100);
        send_beat(20, 16'h0001, 8'hFF, 0, 100);
        settle();
        write_reg(REG_FLAGS, 32'h6);
        send_beat(20, 16'hFFFF, 8'hFF, 0, 100);
        send_beat(20, 16'h0001, 8'h01, 0, 100);

        // Hold the receiver off while beats keep coming, so the input stalls
        settle();
        hold_off = 300;
        repeat (60) random_beat();

        // Random phases
        while (sent < 550) begin
            settle();
            random_config();
            if (sent > 250 && sent < 320) no_idle = 1;
            else no_idle = 0;
            if (sent > 100 && sent < 140) hold_off = 200;
            repeat ($urandom_range(40, 10)) random_beat();
        end

        // Drain and verdict
        no_idle = 0;
        settle();
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
